FILE: rtl/tkh_pkg.sv
// shared types and constants of the bounded top-k max-heap
package tkh_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int DEF_ID_BITS  = 32;

    localparam int DIST_W  = 32;
    localparam int ID_W    = 32;
    localparam int ACT_W   = 2;
    localparam int LIMIT_W = 7;
    localparam int COUNT_W = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    // first member is the most significant: top_distance sits in the lowest bits
    typedef struct packed {
        logic               pop_error;
        logic               is_empty;
        logic [COUNT_W-1:0] kept_count;
        logic [ID_W-1:0]    top_id;
        logic [DIST_W-1:0]  top_distance;
    } t_result;

endpackage

FILE: rtl/tkh_mem.sv
// heap entry memory: one write port, two registered read ports
module tkh_mem #(
    parameter int DEPTH = tkh_pkg::DEF_CAPACITY,
    parameter int WIDTH = tkh_pkg::DIST_W + tkh_pkg::DEF_ID_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: rtl/tkh_ctrl.sv
// heap sequencer: sift-up for inserts, sift-down for pops and top replacement
module tkh_ctrl #(
    parameter int CAPACITY = tkh_pkg::DEF_CAPACITY,
    parameter int ID_BITS  = tkh_pkg::DEF_ID_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [tkh_pkg::ACT_W-1:0]            i_action,
    input  logic [tkh_pkg::DIST_W-1:0]           i_distance,
    input  logic [tkh_pkg::ID_W-1:0]             i_node_id,
    input  logic [$clog2(CAPACITY+1)-1:0]        i_limit,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    output tkh_pkg::t_result                     o_res,
    output logic                                 o_we,
    output logic [$clog2(CAPACITY)-1:0]          o_waddr,
    output logic [tkh_pkg::DIST_W+ID_BITS-1:0]   o_wdata,
    output logic [$clog2(CAPACITY)-1:0]          o_raddr_a,
    output logic [$clog2(CAPACITY)-1:0]          o_raddr_b,
    input  logic [tkh_pkg::DIST_W+ID_BITS-1:0]   i_rdata_a,
    input  logic [tkh_pkg::DIST_W+ID_BITS-1:0]   i_rdata_b
);
    import tkh_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);
    localparam int IW = AW + 2;
    localparam int PW = DIST_W + ID_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POPRD,
        S_UP,
        S_DOWN,
        S_FINAL,
        S_OUT
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_pos, n_pos;
    logic [CW-1:0]   r_size, n_size;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   r_val, n_val;
    logic [PW-1:0]   r_top;
    logic            r_perr, n_perr;

    logic [PW-1:0]   w_pair;
    logic [IW-1:0]   w_lch, w_rch, w_size_ext, w_cidx, w_cl, w_cr;
    logic            w_pick_r;
    logic [PW-1:0]   w_cval;
    logic [AW-1:0]   w_par, w_gpar, w_cnt_par;
    logic [DIST_W-1:0] w_top_dist;

    assign w_pair     = {i_distance, i_node_id[ID_BITS-1:0]};
    assign w_lch      = {1'b0, r_pos, 1'b1};
    assign w_rch      = w_lch + IW'(1);
    assign w_size_ext = IW'(r_size);
    assign w_pick_r   = (w_rch < w_size_ext) && (i_rdata_b > i_rdata_a);
    assign w_cval     = w_pick_r ? i_rdata_b : i_rdata_a;
    assign w_cidx     = w_pick_r ? w_rch : w_lch;
    assign w_cl       = {1'b0, w_cidx[AW-1:0], 1'b1};
    assign w_cr       = w_cl + IW'(1);
    assign w_par      = (r_pos - AW'(1)) >> 1;
    assign w_gpar     = (w_par - AW'(1)) >> 1;
    assign w_cnt_par  = AW'((r_count - CW'(1)) >> 1);
    assign w_top_dist = r_top[PW-1 -: DIST_W];

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_size    = r_size;
        n_count   = r_count;
        n_val     = r_val;
        n_perr    = r_perr;
        o_we      = 1'b0;
        o_waddr   = r_pos;
        o_wdata   = r_val;
        o_raddr_a = '0;
        o_raddr_b = '0;
        o_res_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_perr  = 1'b0;
                    n_state = S_OUT;
                    case (i_action)
                        ACT_ADD: begin
                            if (r_count >= i_limit) begin
                                // full: replace the top only with a strictly nearer candidate
                                if (r_count != '0 && i_distance < w_top_dist) begin
                                    n_val  = w_pair;
                                    n_size = r_count;
                                    n_pos  = '0;
                                    if (r_count <= CW'(1)) begin
                                        n_state = S_FINAL;
                                    end else begin
                                        o_raddr_a = AW'(1);
                                        o_raddr_b = AW'(2);
                                        n_state   = S_DOWN;
                                    end
                                end
                            end else if (r_count < CW'(CAPACITY)) begin
                                n_count = r_count + CW'(1);
                                n_val   = w_pair;
                                n_pos   = AW'(r_count);
                                if (r_count == '0) begin
                                    n_state = S_FINAL;
                                end else begin
                                    o_raddr_a = w_cnt_par;
                                    n_state   = S_UP;
                                end
                            end
                        end
                        ACT_POP: begin
                            if (r_count == '0) begin
                                n_perr = 1'b1;
                            end else begin
                                // last entry moves into the root and sinks
                                o_raddr_a = AW'(r_count - CW'(1));
                                n_count   = r_count - CW'(1);
                                n_size    = r_count - CW'(1);
                                n_pos     = '0;
                                n_state   = S_POPRD;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_POPRD: begin
                n_val = i_rdata_a;
                if (r_size == '0) begin
                    n_state = S_OUT;
                end else if (r_size == CW'(1)) begin
                    n_state = S_FINAL;
                end else begin
                    o_raddr_a = AW'(1);
                    o_raddr_b = AW'(2);
                    n_state   = S_DOWN;
                end
            end
            S_UP: begin
                o_we = 1'b1;
                if (r_val > i_rdata_a) begin
                    // parent moves down one level, next parent is fetched at once
                    o_wdata   = i_rdata_a;
                    n_pos     = w_par;
                    o_raddr_a = w_gpar;
                    if (w_par == '0) begin
                        n_state = S_FINAL;
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DOWN: begin
                o_we = 1'b1;
                if (w_cval > r_val) begin
                    o_wdata   = w_cval;
                    n_pos     = w_cidx[AW-1:0];
                    o_raddr_a = w_cl[AW-1:0];
                    o_raddr_b = w_cr[AW-1:0];
                    if (w_cl >= w_size_ext) begin
                        n_state = S_FINAL;
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            S_FINAL: begin
                o_we    = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_perr  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_perr  <= n_perr;
            r_pos   <= n_pos;
            r_size  <= n_size;
            r_val   <= n_val;
            // root copy kept beside the memory
            if (o_we && o_waddr == '0) begin
                r_top <= o_wdata;
            end
        end
    end

    always_comb begin
        o_res              = '0;
        o_res.kept_count   = COUNT_W'(r_count);
        o_res.is_empty     = (r_count == '0);
        o_res.pop_error    = r_perr;
        if (r_count != '0) begin
            o_res.top_distance = w_top_dist;
            o_res.top_id       = ID_W'(r_top[ID_BITS-1:0]);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("heap count above capacity");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (CW'(o_waddr) < r_count))
        else $error("heap write outside held entries");

    a_perr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_perr) |-> (r_count == '0))
        else $error("pop error with entries held");

    a_count_at_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_count == $past(r_count)))
        else $error("count changed during sift");

endmodule

FILE: rtl/bounded_topk_max_heap.sv
// top level of the bounded top-k max-heap: config register, sequencer, heap memory, output register
//
// Keeps the keep_limit smallest (distance, id) pairs in a binary max-heap.
// s_axis carries one command per transfer: tuser is the action (add, pop,
// query), tdata the candidate distance and node id. Every command yields one
// m_axis transfer with the top pair, the count, the empty flag and the pop
// error, all as after the command.
// A query, a pop on empty or a rejected add goes straight to the result;
// an insert, pop or top replacement runs the sift loop, which visits one
// heap level per cycle through the two registered read ports of the entry
// memory, and the block holds one command at a time.
// The result sits in an output register; a stalled m_axis holds it there
// while the next command is already taken and worked on, and that command
// then waits in its last cycle until the register is free.
// Reset empties the heap at once (no clearing pass) and sets keep_limit to
// 64. The user writes keep_limit by i_cfg_we only while idle; the block does
// not enforce it. 0 acts as 1, values above CAPACITY act as CAPACITY.
module bounded_topk_max_heap #(
    parameter int CAPACITY = tkh_pkg::DEF_CAPACITY,
    parameter int ID_BITS  = tkh_pkg::DEF_ID_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tkh_pkg::LIMIT_W-1:0]   i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,   // distance, node_id
    input  logic [tkh_pkg::ACT_W-1:0]     s_axis_tuser,   // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // top_distance, top_id, kept_count, is_empty, pop_error
    output logic [79:0]                   m_axis_tdata
);
    import tkh_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY+1);
    localparam int PW    = DIST_W + ID_BITS;
    localparam int LIM_W = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int PAD_W = 80 - $bits(t_result);

    logic [LIMIT_W-1:0] r_keep_limit;
    logic [LIM_W-1:0]   w_cfg_ext;
    logic [CW-1:0]      w_limit;

    logic               r_ovalid;
    t_result            r_ores;

    logic               w_res_valid;
    logic               w_res_ready;
    t_result            w_res;

    logic               w_we;
    logic [AW-1:0]      w_waddr, w_raddr_a, w_raddr_b;
    logic [PW-1:0]      w_wdata, w_rdata_a, w_rdata_b;

    assign w_cfg_ext = LIM_W'(r_keep_limit);

    always_comb begin
        if (w_cfg_ext == '0) begin
            w_limit = CW'(1);
        end else if (w_cfg_ext > LIM_W'(CAPACITY)) begin
            w_limit = CW'(CAPACITY);
        end else begin
            w_limit = CW'(w_cfg_ext);
        end
    end

    assign w_res_ready = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_limit <= LIMIT_RESET;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_keep_limit <= i_cfg_wdata;
            end
            if (w_res_ready) begin
                r_ovalid <= w_res_valid;
                if (w_res_valid) begin
                    r_ores <= w_res;
                end
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_ores};

    tkh_ctrl #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_distance  (s_axis_tdata[31:0]),
        .i_node_id   (s_axis_tdata[63:32]),
        .i_limit     (w_limit),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr_a   (w_raddr_a),
        .o_raddr_b   (w_raddr_b),
        .i_rdata_a   (w_rdata_a),
        .i_rdata_b   (w_rdata_b)
    );

    tkh_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (PW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

endmodule
